// ===== rtl/core/lfu_cache_lru_tiebreak_unit_assert.svh =====
// ----------------------------------------------------------------------------
// LFU cache assertion macros
// Concurrent assertion wrappers that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef LFU_CACHE_LRU_TIEBREAK_UNIT_ASSERT_SVH
`define LFU_CACHE_LRU_TIEBREAK_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// The consequent must hold in the same cycle as the antecedent.
`define LFU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: lbl");
// The consequent must hold in the cycle after the antecedent.
`define LFU_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: lbl");
`else
`define LFU_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define LFU_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/core/lfu_lru_pkg.sv =====
// ----------------------------------------------------------------------------
// LFU cache package
// Sizes and codes shared by the LFU cache with recency tie-break.
// ----------------------------------------------------------------------------
package lfu_lru_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int OCC_W    = $clog2(CAPACITY + 1);
    localparam int CNT_W    = 16;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int CFG_W    = 5;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    typedef logic [KEY_W-1:0] t_key;
    typedef logic [VAL_W-1:0] t_val;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [OCC_W-1:0] t_occ;

endpackage

// ===== rtl/core/lfu_cache_lru_tiebreak_unit.sv =====
// ----------------------------------------------------------------------------
// LFU cache with least-recently-used tie-break
// Key-value store of CAPACITY entries, one shared compare unit stepping a scan.
// ----------------------------------------------------------------------------
// Usage: operations arrive on the s_axis stream (tuser selects get or put,
// tdata carries the key and the value to write). Every operation produces
// exactly one result transfer on m_axis: tuser is the hit flag, tdata is the
// read value (stored value on a get hit, all ones on a get miss, zero on put).
// A single comparator walks the entries one per cycle to match the key, count
// the occupancy, find the lowest free slot and choose the eviction victim.
// An operation has an accept cycle, a scan of all CAPACITY entries and an
// update cycle; the result register is loaded at the end of the update cycle.
// A put of a new key that must evict several entries (capacity lowered below
// occupancy) rescans once per eviction. s_axis_tready is high only while no
// operation is in flight; a result may still wait in the output register then.
// If the receiver stalls, the next operation completes its scan and then holds
// in the update cycle until the output register is free. The capacity register
// is written through i_cfg_we/i_cfg_wdata; the user must write it only while
// the block is idle, which the block does not enforce. Reset empties the
// store and sets the capacity to 16; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "lfu_cache_lru_tiebreak_unit_assert.svh"

module lfu_cache_lru_tiebreak_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,    // capacity_in_use
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] lookup_key, [63:32] write_value
    input  logic        s_axis_tuser,   // [0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] read_value
    output logic        m_axis_tuser    // [0] hit
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;

    localparam int CAP = lfu_lru_pkg::CAPACITY;
    localparam lfu_lru_pkg::t_idx IDX_LAST = lfu_lru_pkg::IDX_W'(CAP - 1);

    // Entry storage
    logic [CAP-1:0]         r_valid;
    lfu_lru_pkg::t_key      r_key  [CAP];
    lfu_lru_pkg::t_val      r_val  [CAP];
    lfu_lru_pkg::t_cnt      r_cnt  [CAP];
    lfu_lru_pkg::t_idx      r_rank [CAP];

    // Control and operation registers
    logic [1:0]                       r_state;
    logic [lfu_lru_pkg::CFG_W-1:0]    r_cfg;
    lfu_lru_pkg::t_idx                r_idx;
    logic                             r_mode;
    lfu_lru_pkg::t_key                r_op_key;
    lfu_lru_pkg::t_val                r_op_val;
    lfu_lru_pkg::t_occ                r_cap;

    // Scan accumulators
    logic                  r_hit;
    lfu_lru_pkg::t_idx     r_slot;
    lfu_lru_pkg::t_val     r_hit_val;
    lfu_lru_pkg::t_cnt     r_hit_cnt;
    lfu_lru_pkg::t_idx     r_hit_rank;
    lfu_lru_pkg::t_occ     r_occ;
    logic                  r_free_found;
    lfu_lru_pkg::t_idx     r_free;
    logic                  r_vic_found;
    lfu_lru_pkg::t_idx     r_vic;
    lfu_lru_pkg::t_cnt     r_vic_cnt;
    lfu_lru_pkg::t_idx     r_vic_rank;

    // Output register
    logic                  r_o_valid;
    logic                  r_o_hit;
    lfu_lru_pkg::t_val     r_o_data;

    logic                  in_xfer;
    logic                  out_free;
    lfu_lru_pkg::t_occ     cap_eff;
    logic                  rd_valid;
    lfu_lru_pkg::t_key     rd_key;
    lfu_lru_pkg::t_cnt     rd_cnt;
    lfu_lru_pkg::t_idx     rd_rank;
    logic                  take_vic;
    logic                  need_evict;
    logic                  exec_go;
    logic                  do_touch;
    logic                  do_insert;
    logic                  do_evict;
    logic                  do_write_val;
    lfu_lru_pkg::t_val     res_data;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_o_valid || m_axis_tready;

    always_comb begin
        if (int'(r_cfg) > CAP) begin
            cap_eff = lfu_lru_pkg::OCC_W'(CAP);
        end else begin
            cap_eff = lfu_lru_pkg::OCC_W'(r_cfg);
        end
    end

    // Shared scan port: one entry per cycle.
    assign rd_valid = r_valid[r_idx];
    assign rd_key   = r_key[r_idx];
    assign rd_cnt   = r_cnt[r_idx];
    assign rd_rank  = r_rank[r_idx];

    assign take_vic = rd_valid && (!r_vic_found || (rd_cnt < r_vic_cnt) ||
                      ((rd_cnt == r_vic_cnt) && (rd_rank > r_vic_rank)));

    // A put of a new key into a full store evicts first and rescans.
    assign need_evict = (r_mode == lfu_lru_pkg::MODE_PUT) && (r_cap != '0) && !r_hit &&
                        (r_occ >= r_cap);
    assign exec_go    = (r_state == ST_EXEC) && (need_evict || out_free);

    assign do_touch     = exec_go && r_hit &&
                          ((r_mode == lfu_lru_pkg::MODE_GET) || (r_cap != '0));
    assign do_write_val = exec_go && r_hit && (r_mode == lfu_lru_pkg::MODE_PUT) &&
                          (r_cap != '0);
    assign do_evict     = exec_go && need_evict;
    assign do_insert    = exec_go && !need_evict && !r_hit &&
                          (r_mode == lfu_lru_pkg::MODE_PUT) && (r_cap != '0) && r_free_found;

    always_comb begin
        if (r_mode == lfu_lru_pkg::MODE_PUT) begin
            res_data = '0;
        end else if (r_hit) begin
            res_data = r_hit_val;
        end else begin
            res_data = '1;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cfg     <= lfu_lru_pkg::CFG_W'(16);
            r_valid   <= '0;
            r_o_valid <= 1'b0;
            r_idx     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_state <= ST_SCAN;
                        r_idx   <= '0;
                    end
                end
                ST_SCAN: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == IDX_LAST) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (do_evict) begin
                        r_state <= ST_SCAN;
                        r_idx   <= '0;
                    end else if (exec_go) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            if (do_evict) begin
                r_valid[r_vic] <= 1'b0;
            end
            if (do_insert) begin
                r_valid[r_free] <= 1'b1;
            end
            if (exec_go && !need_evict) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Operation capture, scan accumulators and result payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_mode   <= s_axis_tuser;
            r_op_key <= s_axis_tdata[31:0];
            r_op_val <= s_axis_tdata[63:32];
            r_cap    <= cap_eff;
            r_hit    <= 1'b0;
        end
        if (in_xfer || do_evict) begin
            r_occ        <= '0;
            r_free_found <= 1'b0;
            r_vic_found  <= 1'b0;
        end else if (r_state == ST_SCAN) begin
            if (rd_valid) begin
                r_occ <= r_occ + 1'b1;
            end
            if (rd_valid && (rd_key == r_op_key)) begin
                r_hit      <= 1'b1;
                r_slot     <= r_idx;
                r_hit_val  <= r_val[r_idx];
                r_hit_cnt  <= rd_cnt;
                r_hit_rank <= rd_rank;
            end
            if (!rd_valid && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free       <= r_idx;
            end
            if (take_vic) begin
                r_vic_found <= 1'b1;
                r_vic       <= r_idx;
                r_vic_cnt   <= rd_cnt;
                r_vic_rank  <= rd_rank;
            end
        end
        if (exec_go && !need_evict) begin
            r_o_hit  <= r_hit;
            r_o_data <= res_data;
        end
    end

    // Entry payload; recency ranks shift in parallel, one compare per entry.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CAP; i++) begin
            if (do_touch && r_valid[i] && (r_rank[i] < r_hit_rank)) begin
                r_rank[i] <= r_rank[i] + 1'b1;
            end
            if (do_insert && r_valid[i]) begin
                r_rank[i] <= r_rank[i] + 1'b1;
            end
            if (do_evict && r_valid[i] && (r_rank[i] > r_vic_rank)) begin
                r_rank[i] <= r_rank[i] - 1'b1;
            end
        end
        if (do_touch) begin
            r_rank[r_slot] <= '0;
            if (r_hit_cnt != lfu_lru_pkg::COUNT_MAX) begin
                r_cnt[r_slot] <= r_hit_cnt + 1'b1;
            end
        end
        if (do_write_val) begin
            r_val[r_slot] <= r_op_val;
        end
        if (do_insert) begin
            r_key[r_free]  <= r_op_key;
            r_val[r_free]  <= r_op_val;
            r_cnt[r_free]  <= lfu_lru_pkg::CNT_W'(1);
            r_rank[r_free] <= '0;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tuser  = r_o_hit;

    // A put while the capacity is zero leaves the store untouched.
    `LFU_ASSERT_NXT(a_cap_zero_no_change, i_clk, i_rst_n,
        (r_state == ST_EXEC) && (r_mode == lfu_lru_pkg::MODE_PUT) && (r_cap == '0),
        $stable(r_valid))
    // A new result only ever appears right after an update cycle.
    `LFU_ASSERT_IMP(a_result_from_exec, i_clk, i_rst_n,
        $rose(r_o_valid), $past(r_state) == ST_EXEC)
    // An eviction always has a victim and never runs while the key is present.
    `LFU_ASSERT_IMP(a_evict_has_victim, i_clk, i_rst_n,
        do_evict, r_vic_found && !r_hit && r_valid[r_vic])
    // An accepted operation keeps the input closed until it has finished.
    `LFU_ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n,
        in_xfer, !s_axis_tready)

endmodule
